// ===== hdl/assert_macros.svh =====
// Assertion macros used by the stack machine executor core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define CHK_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define CHK_PROP_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sme_pkg.sv =====
// Stream widths, opcodes, fault codes, operation code and register indexes of the stack machine executor
`timescale 1ns / 1ps
`default_nettype none
package sme_pkg;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 80;

  localparam logic [4:0] OP_HLT  = 5'd0;
  localparam logic [4:0] OP_STO  = 5'd1;
  localparam logic [4:0] OP_JMP  = 5'd2;
  localparam logic [4:0] OP_JMPZ = 5'd3;
  localparam logic [4:0] OP_CALL = 5'd4;
  localparam logic [4:0] OP_RET  = 5'd5;
  localparam logic [4:0] OP_LODI = 5'd6;
  localparam logic [4:0] OP_LODV = 5'd7;
  localparam logic [4:0] OP_IN   = 5'd8;
  localparam logic [4:0] OP_OUT  = 5'd9;
  localparam logic [4:0] OP_LT   = 5'd10;
  localparam logic [4:0] OP_LE   = 5'd11;
  localparam logic [4:0] OP_GT   = 5'd12;
  localparam logic [4:0] OP_GE   = 5'd13;
  localparam logic [4:0] OP_EQ   = 5'd14;
  localparam logic [4:0] OP_NEQ  = 5'd15;
  localparam logic [4:0] OP_NEG  = 5'd16;
  localparam logic [4:0] OP_ADD  = 5'd17;
  localparam logic [4:0] OP_SUB  = 5'd18;
  localparam logic [4:0] OP_MUL  = 5'd19;
  localparam logic [4:0] OP_DIV  = 5'd20;
  localparam logic [4:0] OP_MOD  = 5'd21;
  localparam logic [4:0] OP_POW  = 5'd22;
  localparam logic [4:0] OP_NOT  = 5'd23;
  localparam logic [4:0] OP_AND  = 5'd24;
  localparam logic [4:0] OP_OR   = 5'd25;

  localparam logic [1:0] FLT_NONE = 2'd0;
  localparam logic [1:0] FLT_BAD  = 2'd1;
  localparam logic [1:0] FLT_DIV0 = 2'd2;

  localparam logic OPN_RESTART = 1'b0;

  localparam logic REG_ENTRY_PC    = 1'b0;
  localparam logic REG_STACK_START = 1'b1;
endpackage
`default_nettype wire

// ===== hdl/stack_machine_executor_core.sv =====
// Stack machine executor: one instruction per transaction, store held in one synchronous RAM
// Steps: restart goes straight to the result; ordinary instructions do 3 RAM reads, execute, write back.
// MUL adds shift-add steps until the multiplier runs out of bits, and a finish; DIV and MOD add 64
// quotient bits and a sign fix unless the divisor is 0 or -1. POW with a non-negative exponent adds
// square-and-multiply on the same shift-add multiplier. One instruction in flight, and the result
// waits while the output is full; the next instruction is taken only after the result is issued.
// Reset: pc, sp and registers clear; the RAM is then zeroed one word at a time, no input taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module stack_machine_executor_core #(
  parameter int DATA_DEPTH = 1024,
  parameter int CODE_DEPTH = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // opcode[4:0], arg_base[15:5], arg_value[47:16], in_value[111:48]
  input  wire logic [sme_pkg::IN_TDATA_W-1:0]  s_tdata,
  // operation
  input  wire logic                            s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // next_pc[11:0], out_value[75:12], halted[76], fault[78:77], zero pad[79]
  output logic [sme_pkg::OUT_TDATA_W-1:0]      m_tdata,
  // out_valid
  output logic                                 m_tuser,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [2:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import sme_pkg::*;

  localparam int DW = $clog2(DATA_DEPTH);
  localparam int CW = $clog2(CODE_DEPTH);
  localparam logic [DW-1:0] LAST_ADDR = DW'(DATA_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RB, S_RA, S_RC, S_EX, S_MUL, S_DIV, S_DFIN,
    S_PTST, S_PMR, S_PSQ, S_PMB, S_WB, S_RES
  } state_t;

  state_t state;
  state_t ex_state;

  // configuration registers
  logic [11:0] entry_pc;
  logic [9:0]  stack_start;

  // architectural state
  logic [CW-1:0] pc;
  logic [DW-1:0] sp;

  // latched instruction
  logic [4:0]  opcode_r;
  logic [10:0] base_r;
  logic [31:0] val_r;
  logic [63:0] in_r;

  // operands and pending write
  logic [63:0]   a_val, b_val;
  logic          wr_pend;
  logic [DW-1:0] wr_addr;
  logic [63:0]   wr_data;

  // result fields
  logic        res_out_valid;
  logic [63:0] res_out_value;
  logic        res_halted;
  logic [1:0]  res_fault;

  // shift-add multiplier
  logic [63:0] mul_acc, mul_x, mul_y;
  // restoring divider
  logic [63:0] div_rem, div_quo, div_dvs;
  logic [5:0]  div_cnt;
  logic        div_qneg, div_rneg;
  // power loop
  logic [63:0] pw_r, pw_b, pw_e;

  // clearing pass
  logic          clearing;
  logic [DW-1:0] clr_addr;

  // RAM
  logic [63:0]   mem [DATA_DEPTH];
  logic [63:0]   rdata;
  logic [DW-1:0] rd_addr;
  logic          mem_we, item_we;
  logic [DW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;

  // address arithmetic and datapath helpers
  logic [31:0]   addr_sum;
  logic [DW-1:0] addr, below, above;
  logic [CW-1:0] target;
  logic signed [63:0] a_s, b_s;
  logic [63:0]   mul_sum, neg_a, neg_b;
  logic [64:0]   div_sh, div_sub;
  logic [63:0]   pw_e_sh;
  logic [31:0]   pc_ext, entry_ext, start_ext;
  logic          apb_wr;

  assign addr_sum  = {{21{base_r[10]}}, base_r} + val_r;
  assign addr      = addr_sum[DW-1:0];
  assign below     = sp - 1'b1;
  assign above     = sp + 1'b1;
  assign target    = val_r[CW-1:0];
  assign a_s       = a_val;
  assign b_s       = b_val;
  assign neg_a     = 64'd0 - a_val;
  assign neg_b     = 64'd0 - b_val;
  assign mul_sum   = mul_acc + mul_x;
  assign div_sh    = {div_rem, div_quo[63]};
  assign div_sub   = div_sh - {1'b0, div_dvs};
  assign pw_e_sh   = {1'b0, pw_e[63:1]};
  assign pc_ext    = 32'(pc);
  assign entry_ext = 32'(entry_pc);
  assign start_ext = 32'(stack_start);

  // APB register file
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {22'd0, stack_start} : {20'd0, entry_pc};

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_pc    <= '0;
      stack_start <= '0;
    end else if (apb_wr) begin
      case (paddr[2])
        REG_ENTRY_PC:    entry_pc    <= pwdata[11:0];
        REG_STACK_START: stack_start <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // clear the RAM after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) clearing <= 1'b0;
    end
  end

  // RAM read address follows the read phase
  always_comb begin
    case (state)
      S_RB:    rd_addr = sp;
      S_RA:    rd_addr = below;
      default: rd_addr = addr;
    endcase
  end

  // successor of execute: iterate for multiply, divide by other than 0/-1, non-negative power
  always_comb begin
    case (opcode_r)
      OP_MUL:         ex_state = S_MUL;
      OP_DIV, OP_MOD: ex_state = (b_val == 64'd0 || b_val == '1) ? S_WB : S_DIV;
      OP_POW:         ex_state = b_val[63] ? S_WB : S_PTST;
      default:        ex_state = S_WB;
    endcase
  end

  assign item_we   = (state == S_WB) && wr_pend;
  assign mem_we    = clearing || item_we;
  assign mem_waddr = clearing ? clr_addr : wr_addr;
  assign mem_wdata = clearing ? 64'd0 : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[rd_addr];
  end

  assign s_tready = (state == S_IDLE) && !clearing;

  // instruction sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pc       <= '0;
      sp       <= '0;
      m_tvalid <= 1'b0;
      wr_pend  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_RES)) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            opcode_r      <= s_tdata[4:0];
            base_r        <= s_tdata[15:5];
            val_r         <= s_tdata[47:16];
            in_r          <= s_tdata[111:48];
            res_out_valid <= 1'b0;
            res_out_value <= '0;
            res_halted    <= 1'b0;
            res_fault     <= FLT_NONE;
            wr_pend       <= 1'b0;
            if (s_tuser == OPN_RESTART) begin
              pc    <= entry_ext[CW-1:0];
              sp    <= start_ext[DW-1:0];
              state <= S_RES;
            end else begin
              pc    <= pc + 1'b1;
              state <= S_RB;
            end
          end
        end
        S_RB: state <= S_RA;
        S_RA: begin
          b_val <= rdata;
          state <= S_RC;
        end
        S_RC: begin
          a_val <= rdata;
          state <= S_EX;
        end
        S_EX: begin
          // binary ops write below and pop
          state <= ex_state;
          case (opcode_r)
            OP_HLT: res_halted <= 1'b1;
            OP_STO: begin
              wr_addr <= addr;
              wr_data <= b_val;
              wr_pend <= 1'b1;
              sp      <= below;
            end
            OP_JMP, OP_CALL: pc <= target;
            OP_JMPZ: begin
              if (b_val == 64'd0) pc <= target;
              sp <= below;
            end
            OP_RET: begin
              pc      <= a_val[CW-1:0];
              wr_addr <= below;
              wr_data <= b_val;
              wr_pend <= 1'b1;
              sp      <= below;
            end
            OP_LODI: begin
              wr_addr <= above;
              wr_data <= {{32{val_r[31]}}, val_r};
              wr_pend <= 1'b1;
              sp      <= above;
            end
            OP_LODV: begin
              wr_addr <= above;
              wr_data <= rdata;
              wr_pend <= 1'b1;
              sp      <= above;
            end
            OP_IN: begin
              wr_addr <= (base_r == '1) ? sp : addr;
              wr_data <= in_r;
              wr_pend <= 1'b1;
            end
            OP_OUT: begin
              res_out_valid <= 1'b1;
              res_out_value <= b_val;
              sp            <= below;
            end
            OP_LT, OP_LE, OP_GT, OP_GE, OP_EQ, OP_NEQ, OP_ADD, OP_SUB, OP_AND, OP_OR: begin
              wr_addr <= below;
              wr_pend <= 1'b1;
              sp      <= below;
              case (opcode_r)
                OP_LT:   wr_data <= {63'd0, a_s < b_s};
                OP_LE:   wr_data <= {63'd0, a_s <= b_s};
                OP_GT:   wr_data <= {63'd0, a_s > b_s};
                OP_GE:   wr_data <= {63'd0, a_s >= b_s};
                OP_EQ:   wr_data <= {63'd0, a_val == b_val};
                OP_NEQ:  wr_data <= {63'd0, a_val != b_val};
                OP_ADD:  wr_data <= a_val + b_val;
                OP_SUB:  wr_data <= a_val - b_val;
                OP_AND:  wr_data <= {63'd0, (a_val != 64'd0) && (b_val != 64'd0)};
                default: wr_data <= {63'd0, (a_val != 64'd0) || (b_val != 64'd0)};
              endcase
            end
            OP_NEG: begin
              wr_addr <= sp;
              wr_data <= neg_b;
              wr_pend <= 1'b1;
            end
            OP_NOT: begin
              wr_addr <= sp;
              wr_data <= {63'd0, b_val == 64'd0};
              wr_pend <= 1'b1;
            end
            OP_MUL: begin
              wr_addr <= below;
              wr_pend <= 1'b1;
              sp      <= below;
              mul_acc <= '0;
              mul_x   <= a_val;
              mul_y   <= b_val;
            end
            OP_DIV, OP_MOD: begin
              wr_addr <= below;
              wr_pend <= 1'b1;
              sp      <= below;
              if (b_val == 64'd0) begin
                wr_data   <= '0;
                res_fault <= FLT_DIV0;
              end else if (b_val == '1) begin
                wr_data <= (opcode_r == OP_DIV) ? neg_a : 64'd0;
              end else begin
                div_rem  <= '0;
                div_quo  <= a_val[63] ? neg_a : a_val;
                div_dvs  <= b_val[63] ? neg_b : b_val;
                div_qneg <= a_val[63] ^ b_val[63];
                div_rneg <= a_val[63];
                div_cnt  <= '0;
              end
            end
            OP_POW: begin
              wr_addr <= below;
              wr_pend <= 1'b1;
              sp      <= below;
              if (b_val[63]) begin
                if (a_val == 64'd1) wr_data <= 64'd1;
                else if (a_val == '1) wr_data <= b_val[0] ? '1 : 64'd1;
                else wr_data <= '0;
              end else begin
                pw_r  <= 64'd1;
                pw_b  <= a_val;
                pw_e  <= b_val;
              end
            end
            default: res_fault <= FLT_BAD;
          endcase
        end
        // one shift-add step a cycle; finish when the multiplier runs out of bits
        S_MUL, S_PMR, S_PMB: begin
          if (mul_y == 64'd0) begin
            case (state)
              S_MUL: begin
                wr_data <= mul_acc;
                state   <= S_WB;
              end
              S_PMR: begin
                pw_r  <= mul_acc;
                state <= S_PSQ;
              end
              default: begin
                pw_b  <= mul_acc;
                state <= S_PTST;
              end
            endcase
          end else begin
            if (mul_y[0]) mul_acc <= mul_sum;
            mul_x <= {mul_x[62:0], 1'b0};
            mul_y <= {1'b0, mul_y[63:1]};
          end
        end
        // one quotient bit a cycle
        S_DIV: begin
          if (!div_sub[64]) begin
            div_rem <= div_sub[63:0];
            div_quo <= {div_quo[62:0], 1'b1};
          end else begin
            div_rem <= div_sh[63:0];
            div_quo <= {div_quo[62:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == '1) state <= S_DFIN;
        end
        S_DFIN: begin
          if (opcode_r == OP_DIV) wr_data <= div_qneg ? 64'd0 - div_quo : div_quo;
          else wr_data <= div_rneg ? 64'd0 - div_rem : div_rem;
          state <= S_WB;
        end
        S_PTST: begin
          if (pw_e == 64'd0) begin
            wr_data <= pw_r;
            state   <= S_WB;
          end else if (pw_e[0]) begin
            mul_acc <= '0;
            mul_x   <= pw_r;
            mul_y   <= pw_b;
            state   <= S_PMR;
          end else begin
            state <= S_PSQ;
          end
        end
        S_PSQ: begin
          pw_e <= pw_e_sh;
          if (pw_e_sh == 64'd0) begin
            wr_data <= pw_r;
            state   <= S_WB;
          end else begin
            mul_acc <= '0;
            mul_x   <= pw_b;
            mul_y   <= pw_b;
            state   <= S_PMB;
          end
        end
        S_WB: state <= S_RES;
        S_RES: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, res_fault, res_halted, res_out_value, pc_ext[11:0]};
            m_tuser  <= res_out_valid;
            wr_pend  <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_PROP(a_accept_after_clear, (s_tvalid && s_tready) |-> !clearing, "item taken during clear")
  `CHK_PROP(a_busy_not_clearing, (state != S_IDLE) |-> !clearing, "busy during clear")
  `CHK_PROP(a_accept_next, (s_tvalid && s_tready) |=> (state == S_RB || state == S_RES), "bad start")
  `CHK_PROP(a_div0_fault, (state == S_RES && res_fault == FLT_DIV0) |-> (opcode_r == OP_DIV || opcode_r == OP_MOD), "stray divide fault")
  `CHK_PROP_ALWAYS(a_item_write, item_we |-> !clearing, "item write during clear")

endmodule
`default_nettype wire
